/* rtl/core/lles_pkg.sv */
// Shared types and constants of the LED light effect sequencer.
// No dependencies; imported by the sequencer, effect and speed modules.
package lles_pkg;

  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutW      = 38;
  localparam int unsigned OutTdataW = 40;
  localparam int unsigned CfgIdxW   = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDefaultPeriod = 1'd0;
  localparam logic [CfgIdxW-1:0] RegPeriodLimit   = 1'd1;

  localparam logic [7:0] DefaultPeriodRst = 8'd20;
  localparam logic [7:0] PeriodLimitRst   = 8'd200;
  localparam logic [4:0] ModeRst          = 5'd1;
  localparam logic [2:0] SpeedMask        = 3'h7;

  // mode bits, lowest set bit wins
  localparam int unsigned ModeFill     = 0;
  localparam int unsigned ModeForward  = 1;
  localparam int unsigned ModeBackward = 2;
  localparam int unsigned ModeKnight   = 3;
  localparam int unsigned ModeDual     = 4;

  // speed button bits
  localparam int unsigned BtnInc     = 0;
  localparam int unsigned BtnDec     = 1;
  localparam int unsigned BtnRestore = 2;

  typedef struct packed {
    logic [31:0] pattern_word;
    logic [7:0]  row_one;
    logic [7:0]  row_two;
    logic        direction;
    logic [7:0]  output_byte;
  } effect_state_t;

  typedef struct packed {
    logic [7:0] period;
    logic [2:0] held;
  } speed_state_t;

endpackage

/* rtl/core/led_light_effect_sequencer.sv */
// LED light effect sequencer: one sync tick per input transaction.
// Results are registered in the result buffer; throughput 1 transaction per
// cycle, set by the single-pass state update and the two-entry result buffer.
// Input stalls only while both result entries wait on the output side.
// Async active-low reset: mode fill-up, period and registers to defaults.
module led_light_effect_sequencer #(
  parameter int unsigned LEDS_PER_ROW = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] local_buttons, [15:8] remote_speed_buttons,
  // [23:16] remote_mode_a, [31:24] remote_mode_b
  input  logic [lles_pkg::InTdataW-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] led_row_one, [15:8] led_row_two, [23:16] own_output,
  // [28:24] active_mode, [36:29] step_period, [37] stepped, [39:38] zero
  output logic [lles_pkg::OutTdataW-1:0]     m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lles_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [7:0]                         cfg_data_i
);
  import lles_pkg::*;

  logic [7:0]    default_period_q, period_limit_q;
  logic [4:0]    mode_q, mode_d;
  logic [7:0]    tick_q, tick_d;
  effect_state_t eff_q, eff_next, eff_d;
  speed_state_t  spd_q, spd_d;
  logic [2:0]    speed;
  logic [4:0]    modesel;
  logic          step;
  logic          accept;
  logic [OutW-1:0] result;
  logic [OutW-1:0] out_payload;

  assign speed   = (s_axis_tdata[2:0] | s_axis_tdata[10:8]) & SpeedMask;
  assign modesel = s_axis_tdata[20:16] | s_axis_tdata[28:24];
  assign mode_d  = (modesel != 5'd0) ? modesel : mode_q;
  assign step    = (tick_q <= 8'd1);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  lles_effect #(
    .LEDS_PER_ROW(LEDS_PER_ROW)
  ) u_effect (
    .mode_i(mode_d),
    .cur_i (eff_q),
    .nxt_o (eff_next)
  );

  lles_speed u_speed (
    .speed_i         (speed),
    .default_period_i(default_period_q),
    .period_limit_i  (period_limit_q),
    .cur_i           (spd_q),
    .nxt_o           (spd_d)
  );

  assign eff_d  = step ? eff_next : eff_q;
  // reload from the period before this tick's buttons
  assign tick_d = step ? spd_q.period : tick_q - 8'd1;

  assign result = {step, spd_d.period, mode_d, eff_d.output_byte,
                   eff_d.row_two, eff_d.row_one};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_period_q <= DefaultPeriodRst;
      period_limit_q   <= PeriodLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegDefaultPeriod: default_period_q <= cfg_data_i;
        RegPeriodLimit:   period_limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeRst;
      tick_q <= 8'd0;
      eff_q  <= '0;
      spd_q  <= '{period: DefaultPeriodRst, held: 3'd0};
    end else if (accept) begin
      mode_q <= mode_d;
      tick_q <= tick_d;
      eff_q  <= eff_d;
      spd_q  <= spd_d;
    end
  end

  lles_out_fifo #(
    .Width(OutW)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(s_axis_tvalid),
    .wr_ready_o(s_axis_tready),
    .wr_data_i (result),
    .rd_valid_o(m_axis_tvalid),
    .rd_ready_i(m_axis_tready),
    .rd_data_o (out_payload)
  );

  assign m_axis_tdata = {{(OutTdataW - OutW){1'b0}}, out_payload};

`ifndef SYNTH
  a_tick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && tick_q > 8'd1) |=> (tick_q == $past(tick_q) - 8'd1))
    else $error("tick counter did not count down");

  a_mode_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != 5'd0)
    else $error("stored mode bits cleared");

  a_inc_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && spd_q.held == 3'd0 && speed[BtnInc] && spd_q.period < period_limit_q)
    |=> (spd_q.period == $past(spd_q.period) + 8'd1))
    else $error("increment button did not raise the period");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");
`endif

endmodule

/* rtl/core/lles_effect.sv */
// Next pattern state for one step of the selected light effect.
// Depends on lles_pkg for the effect state struct and mode bit positions.
module lles_effect #(
  parameter int unsigned LEDS_PER_ROW = 5
) (
  input  logic [4:0]             mode_i,
  input  lles_pkg::effect_state_t cur_i,
  output lles_pkg::effect_state_t nxt_o
);
  import lles_pkg::*;

  localparam logic [31:0] RowMask  = (32'd1 << LEDS_PER_ROW) - 32'd1;
  localparam logic [31:0] BothMask = (32'd1 << (2 * LEDS_PER_ROW)) - 32'd1;
  localparam logic [31:0] BackTop  = 32'd1 << (2 * LEDS_PER_ROW);
  localparam logic [7:0]  RowTop   = 8'(32'd1 << (LEDS_PER_ROW - 1));
  localparam logic [7:0]  RowMask8 = RowMask[7:0];

  logic [31:0] pw_shl;
  logic [31:0] pw_shr;
  logic [31:0] pw_new;
  logic        use_word;

  assign pw_shl = cur_i.pattern_word << 1;
  assign pw_shr = cur_i.pattern_word >> 1;

  always_comb begin
    nxt_o    = cur_i;
    pw_new   = cur_i.pattern_word;
    use_word = 1'b0;
    if (mode_i[ModeFill]) begin
      use_word = 1'b1;
      if (cur_i.direction) begin
        if ((cur_i.pattern_word & BothMask) == 32'd0) begin
          pw_new = 32'd1;
        end else begin
          pw_new = pw_shl + 32'd1;
          if (pw_new >= BothMask) begin
            nxt_o.direction = 1'b0;
          end
        end
      end else begin
        pw_new = pw_shl;
        if ((pw_shl & BothMask) == 32'd0) begin
          nxt_o.direction = 1'b1;
        end
      end
    end else if (mode_i[ModeForward]) begin
      use_word = 1'b1;
      pw_new   = (pw_shl > BothMask || pw_shl == 32'd0) ? 32'd1 : pw_shl;
    end else if (mode_i[ModeBackward]) begin
      use_word = 1'b1;
      pw_new   = (pw_shr > BothMask || pw_shr == 32'd0) ? BackTop : pw_shr;
    end else if (mode_i[ModeKnight]) begin
      if (cur_i.row_one == 8'd0) begin
        nxt_o.row_one   = 8'd1;
        nxt_o.direction = 1'b1;
      end else if (cur_i.direction) begin
        nxt_o.row_one = cur_i.row_one << 1;
        if (nxt_o.row_one >= RowTop) begin
          nxt_o.direction = 1'b0;
        end
      end else begin
        nxt_o.row_one = cur_i.row_one >> 1;
        if (nxt_o.row_one <= 8'd1) begin
          nxt_o.direction = 1'b1;
        end
      end
      nxt_o.row_two = nxt_o.row_one;
    end else if (mode_i[ModeDual]) begin
      if (cur_i.row_one == 8'd0 || cur_i.row_two == 8'd0 ||
          (cur_i.row_two & ~RowMask8) != 8'd0) begin
        nxt_o.row_one   = 8'd1;
        nxt_o.row_two   = RowTop;
        nxt_o.direction = 1'b1;
      end else if (cur_i.direction) begin
        nxt_o.row_one = cur_i.row_one << 1;
        nxt_o.row_two = cur_i.row_two >> 1;
        if (nxt_o.row_one >= RowTop) begin
          nxt_o.direction = 1'b0;
        end
      end else begin
        nxt_o.row_one = cur_i.row_one >> 1;
        nxt_o.row_two = cur_i.row_two << 1;
        if (nxt_o.row_one <= 8'd1) begin
          nxt_o.direction = 1'b1;
        end
      end
    end
    if (use_word) begin
      nxt_o.pattern_word = pw_new;
      nxt_o.row_one      = 8'(pw_new & RowMask);
      nxt_o.row_two      = 8'((pw_new >> LEDS_PER_ROW) & RowMask);
    end
    nxt_o.output_byte = nxt_o.row_one;
  end

endmodule

/* rtl/core/lles_speed.sv */
// Edge-qualified speed buttons: increment, decrement and restore of the period.
// Depends on lles_pkg for the speed state struct and button bit positions.
module lles_speed (
  input  logic [2:0]             speed_i,
  input  logic [7:0]             default_period_i,
  input  logic [7:0]             period_limit_i,
  input  lles_pkg::speed_state_t cur_i,
  output lles_pkg::speed_state_t nxt_o
);
  import lles_pkg::*;

  always_comb begin
    nxt_o = cur_i;
    if (cur_i.held == 3'd0) begin
      if (speed_i[BtnInc]) begin
        if (cur_i.period < period_limit_i) begin
          nxt_o.period = cur_i.period + 8'd1;
        end
        nxt_o.held = speed_i;
      end else if (speed_i[BtnDec]) begin
        if (cur_i.period > 8'd1) begin
          nxt_o.period = cur_i.period - 8'd1;
        end
        nxt_o.held = speed_i;
      end else if (speed_i[BtnRestore]) begin
        nxt_o.period = default_period_i;
        nxt_o.held   = speed_i;
      end
    end else if (speed_i == 3'd0) begin
      // re-arm once all buttons are released
      nxt_o.held = 3'd0;
    end
  end

endmodule

/* rtl/core/lles_out_fifo.sv */
// Two-entry result buffer that decouples the input side from output stalls.
// Depends on nothing; sized by its Width parameter.
module lles_out_fifo #(
  parameter int unsigned Width = 38
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* tb/lles_checker.sv */
// Scoreboard for the LED light effect sequencer: watches the tick, frame and register channels.
// It predicts every LED frame from its own copy of the sequencer state and compares it.
// Depends on lles_pkg for the widths, register indexes, mode bits and button bits.
module lles_checker #(
  parameter int unsigned LedsPerRow = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tick_valid_i,
  input  logic                           tick_ready_i,
  input  logic [lles_pkg::InTdataW-1:0]  tick_data_i,
  input  logic                           frame_valid_i,
  input  logic                           frame_ready_i,
  input  logic [lles_pkg::OutTdataW-1:0] frame_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [lles_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  output int                             pending_o,
  output int                             errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lles_pkg::*;

  localparam logic [31:0] BothMask = (32'd1 << (2 * LedsPerRow)) - 32'd1;
  localparam logic [7:0]  RowMask  = 8'((1 << LedsPerRow) - 1);
  localparam logic [7:0]  RowTop   = 8'(1 << (LedsPerRow - 1));
  localparam int          NumFields = 7;

  // frame layout, lowest bit up
  int    field_lo   [NumFields] = '{0, 8, 16, 24, 29, 37, 38};
  int    field_w    [NumFields] = '{8, 8, 8, 5, 8, 1, 2};
  string field_name [NumFields] = '{"led_row_one", "led_row_two", "own_output",
                                    "active_mode", "step_period", "stepped", "pad"};

  logic [7:0]  dflt_period;
  logic [7:0]  period_lim;
  logic [31:0] pat_word;
  logic [7:0]  row1;
  logic [7:0]  row2;
  logic        dir_up;
  logic [4:0]  mode;
  logic [7:0]  tick_cnt;
  logic [7:0]  period;
  logic [2:0]  held;
  logic [7:0]  out_byte;

  logic [OutTdataW-1:0] led_frames_q[$];
  int                   err_cnt;

  function automatic void reset_sequencer();
    dflt_period = DefaultPeriodRst;
    period_lim  = PeriodLimitRst;
    pat_word    = '0;
    row1        = '0;
    row2        = '0;
    dir_up      = 1'b0;
    mode        = ModeRst;
    tick_cnt    = '0;
    period      = DefaultPeriodRst;
    held        = '0;
    out_byte    = '0;
  endfunction

  function automatic void split_word();
    row1 = pat_word[7:0] & RowMask;
    row2 = 8'(pat_word >> LedsPerRow) & RowMask;
  endfunction

  function automatic void advance_pattern();
    if (mode[ModeFill]) begin
      if (dir_up) begin
        if ((pat_word & BothMask) == '0) begin
          pat_word = 32'd1;
        end else begin
          pat_word = (pat_word << 1) + 32'd1;
          if (pat_word >= BothMask) dir_up = 1'b0;
        end
      end else begin
        pat_word = pat_word << 1;
        if ((pat_word & BothMask) == '0) dir_up = 1'b1;
      end
      split_word();
    end else if (mode[ModeForward]) begin
      pat_word = pat_word << 1;
      if (pat_word > BothMask || pat_word == '0) pat_word = 32'd1;
      split_word();
    end else if (mode[ModeBackward]) begin
      pat_word = pat_word >> 1;
      // restart one position past both rows, so one step is dark
      if (pat_word > BothMask || pat_word == '0) pat_word = 32'd1 << (2 * LedsPerRow);
      split_word();
    end else if (mode[ModeKnight]) begin
      if (row1 == '0) begin
        row1   = 8'd1;
        dir_up = 1'b1;
      end else if (dir_up) begin
        row1 = row1 << 1;
        if (row1 >= RowTop) dir_up = 1'b0;
      end else begin
        row1 = row1 >> 1;
        if (row1 <= 8'd1) dir_up = 1'b1;
      end
      row2 = row1;
    end else if (mode[ModeDual]) begin
      if (row1 == '0 || row2 == '0 || (row2 & ~RowMask) != '0) begin
        row1   = 8'd1;
        row2   = RowTop;
        dir_up = 1'b1;
      end else if (dir_up) begin
        row1 = row1 << 1;
        row2 = row2 >> 1;
        if (row1 >= RowTop) dir_up = 1'b0;
      end else begin
        row1 = row1 >> 1;
        row2 = row2 << 1;
        if (row1 <= 8'd1) dir_up = 1'b1;
      end
    end
    out_byte = row1;
  endfunction

  function automatic logic [OutTdataW-1:0] sequence_tick(input logic [InTdataW-1:0] d);
    logic [2:0] speed;
    logic [4:0] mode_sel;
    logic       stepped;
    speed    = d[2:0] | d[10:8];
    mode_sel = d[20:16] | d[28:24];
    stepped  = 1'b0;
    if (mode_sel != '0) mode = mode_sel;
    if (tick_cnt <= 8'd1) begin
      advance_pattern();
      tick_cnt = period;
      stepped  = 1'b1;
    end else begin
      tick_cnt = tick_cnt - 8'd1;
    end
    // buttons act on the press only; re-arm once all are released
    if (held == '0) begin
      if (speed[BtnInc]) begin
        if (period < period_lim) period = period + 8'd1;
        held = speed;
      end else if (speed[BtnDec]) begin
        if (period > 8'd1) period = period - 8'd1;
        held = speed;
      end else if (speed[BtnRestore]) begin
        period = dflt_period;
        held   = speed;
      end
    end else if (speed == '0) begin
      held = '0;
    end
    return {2'b00, stepped, period, mode, out_byte, row2, row1};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OutTdataW-1:0] want;
    logic [OutTdataW-1:0] want_f;
    logic [OutTdataW-1:0] got_f;
    logic [OutTdataW-1:0] mask;
    if (!rst_ni) begin
      reset_sequencer();
      led_frames_q.delete();
      err_cnt = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegDefaultPeriod) dflt_period = cfg_data_i;
        else if (cfg_index_i == RegPeriodLimit) period_lim = cfg_data_i;
      end
      if (tick_valid_i && tick_ready_i) led_frames_q.push_back(sequence_tick(tick_data_i));
      if (frame_valid_i && frame_ready_i) begin
        if (led_frames_q.size() == 0) begin
          $display("%0t: unexpected frame, expected none, got %h", $time, frame_data_i);
          err_cnt++;
        end else begin
          want = led_frames_q.pop_front();
          for (int i = 0; i < NumFields; i++) begin
            mask   = (40'd1 << field_w[i]) - 40'd1;
            want_f = (want >> field_lo[i]) & mask;
            got_f  = (frame_data_i >> field_lo[i]) & mask;
            if (want_f != got_f) begin
              $display("%0t: %s expected %0h, got %0h", $time, field_name[i], want_f, got_f);
              err_cnt++;
            end
          end
        end
      end
      pending_o <= led_frames_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

/* tb/tb.sv */
// Top of the LED light effect sequencer testbench: clock, reset, tick stimulus, frame back-pressure.
// Depends on lles_pkg, led_light_effect_sequencer and lles_checker, which predicts and compares.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lles_pkg::*;

  localparam int unsigned LedsPerRow    = 5;
  localparam int          WatchdogLimit = 1000;
  localparam logic [7:0]  PressInc      = 8'(1 << BtnInc);
  localparam logic [7:0]  PressDec      = 8'(1 << BtnDec);
  localparam logic [7:0]  PressRestore  = 8'(1 << BtnRestore);

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [7:0]           cfg_data_i;
  int                   pending;
  int                   failures;
  int                   stall_cycles;
  bit                   idle_on;

  led_light_effect_sequencer #(.LEDS_PER_ROW(LedsPerRow)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  lles_checker #(.LedsPerRow(LedsPerRow)) u_checker (
    .clk_i, .rst_ni,
    .tick_valid_i(s_axis_tvalid), .tick_ready_i(s_axis_tready), .tick_data_i(s_axis_tdata),
    .frame_valid_i(m_axis_tvalid), .frame_ready_i(m_axis_tready), .frame_data_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [InTdataW-1:0] tick_word(input logic [7:0] lb, input logic [7:0] rs,
                                                    input logic [7:0] ma, input logic [7:0] mb);
    return {mb, ma, rs, lb};
  endfunction

  // mostly quiet ticks with random unused bits; now and then a button or a mode change
  function automatic logic [InTdataW-1:0] rand_tick(input int mode_pct);
    logic [7:0] lb;
    logic [7:0] rs;
    logic [7:0] ma;
    logic [7:0] mb;
    int         r;
    lb = 8'($urandom);
    rs = 8'($urandom);
    ma = 8'($urandom);
    mb = 8'($urandom);
    lb[2:0] = '0;
    rs[2:0] = '0;
    ma[4:0] = '0;
    mb[4:0] = '0;
    r = $urandom_range(0, 99);
    if (r < 4) lb[2:0] = 3'(1 << $urandom_range(0, 2));
    else if (r < 8) rs[2:0] = 3'(1 << $urandom_range(0, 2));
    else if (r < 11) begin
      lb[2:0] = 3'($urandom_range(0, 7));
      rs[2:0] = 3'($urandom_range(0, 7));
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      ma[4:0] = 5'($urandom_range(0, 31));
      mb[4:0] = 5'($urandom_range(0, 31));
    end else if (r < mode_pct) begin
      if ($urandom_range(0, 1) == 0) ma[4:0] = 5'(1 << $urandom_range(0, 4));
      else mb[4:0] = 5'(1 << $urandom_range(0, 4));
    end
    return tick_word(lb, rs, ma, mb);
  endfunction

  // leaves tvalid high; the caller drops it with a gap or a drain
  task automatic send_tick(input logic [InTdataW-1:0] d);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_regs(input logic [7:0] dflt, input logic [7:0] limit);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegDefaultPeriod;
    cfg_data_i  <= dflt;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= RegPeriodLimit;
    cfg_data_i  <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] dflt, input logic [7:0] limit, input int count,
                           input int mode_pct, input bit idle, input bit drain_mid);
    idle_on = idle;
    wait_drained();
    write_regs(dflt, limit);
    // press restore, which loads the new default unless a button is still held, then release
    send_tick(tick_word(PressRestore, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(8'h00, 8'h00, 8'h00, 8'h00));
    for (int i = 0; i < count; i++) begin
      if (drain_mid && i == count / 2) wait_drained();
      send_tick(rand_tick(mode_pct));
    end
  endtask

  // frame side back-pressure
  initial begin
    m_axis_tready <= 1'b0;
    repeat (8) @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    idle_on = 1'b1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= RegDefaultPeriod;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_regs(8'd1, 8'd255);
    send_tick(tick_word(8'h00, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_tick(tick_word(8'h00, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(PressDec, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(8'h00, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(8'h00, PressInc, 8'h00, 8'h00));
    send_tick(tick_word(8'hF8, 8'hF8, 8'hE0, 8'hE0));
    send_tick(tick_word(8'h00, PressRestore, 8'h00, 8'h00));
    send_tick(tick_word(PressInc, 8'h00, 8'h00, 8'h00));
    // held buttons must not act again until all are released
    send_tick(tick_word(PressInc | PressDec, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(8'h00, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(PressDec, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(8'h00, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(PressDec, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(8'h00, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(8'h00, 8'h00, 8'(1 << ModeForward), 8'h00));
    send_tick(tick_word(8'h00, 8'h00, 8'h00, 8'(1 << ModeBackward)));
    send_tick(tick_word(8'h00, 8'h00, 8'(1 << ModeKnight), 8'h00));
    send_tick(tick_word(8'h00, 8'h00, 8'h00, 8'(1 << ModeDual)));
    send_tick(tick_word(8'h00, 8'h00, 8'(1 << ModeDual), 8'(1 << ModeKnight)));
    send_tick(tick_word(8'h00, 8'h00, 8'(1 << ModeFill), 8'h00));
    send_tick(tick_word(8'hFF, 8'h00, 8'h00, 8'h00));
    send_tick(tick_word(8'h00, 8'hFF, 8'h00, 8'h00));
    send_tick(tick_word(8'h00, 8'h00, 8'hFF, 8'h00));
    send_tick(tick_word(8'h00, 8'h00, 8'h00, 8'hFF));

    run_phase(8'd1,   8'd255, 350, 3, 1'b1, 1'b0);
    run_phase(8'd2,   8'd3,   250, 6, 1'b1, 1'b0);
    // zero default period: the pattern steps on every tick
    run_phase(8'd0,   8'd1,   250, 5, 1'b1, 1'b0);
    run_phase(8'd255, 8'd255, 200, 5, 1'b0, 1'b0);
    run_phase(8'd1,   8'd1,   250, 8, 1'b1, 1'b0);
    run_phase(8'd5,   8'd100, 250, 5, 1'b1, 1'b1);
    run_phase(8'd1,   8'd200, 350, 4, 1'b0, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
